FILE: hdl/btlm_pkg.sv
// Package for the truncated linear min-sum message block.
// Holds sequencer states, register map codes, field widths and reset values.
// No dependencies.
package btlm_pkg;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FWD,
        ST_BWD,
        ST_BASE,
        ST_EMIT
    } t_state;

    typedef logic [1:0] t_reg_idx;

    localparam t_reg_idx REG_LABEL_COUNT = 2'd0;
    localparam t_reg_idx REG_SLOPE       = 2'd1;
    localparam t_reg_idx REG_TRUNC_COST  = 2'd2;

    localparam int CFG_AW  = 4;
    localparam int CFG_DW  = 32;
    localparam int LC_W    = 7;
    localparam int SLOPE_W = 16;
    localparam int TRUNC_W = 17;
    localparam int OUT_W   = 18;
    localparam int LABEL_W = 6;

    localparam logic [LC_W-1:0]    LABEL_COUNT_RST = 7'd16;
    localparam logic [SLOPE_W-1:0] SLOPE_RST       = 16'd16;
    localparam logic [TRUNC_W-1:0] TRUNC_COST_RST  = 17'd32;

endpackage

FILE: hdl/btlm_relax.sv
// Shared relaxation unit of the distance-transform passes: min(prev + slope, cur).
// Depends on btlm_pkg for the slope width.
module btlm_relax
    import btlm_pkg::*;
#(
    parameter int SW = 18,
    parameter int EW = 19
) (
    input  logic signed [SW-1:0]      i_prev,
    input  logic        [SLOPE_W-1:0] i_slope,
    input  logic signed [SW-1:0]      i_cur,
    output logic signed [SW-1:0]      o_min
);

    logic signed [EW-1:0] cand;
    logic signed [EW-1:0] cur_x;

    assign cand  = {{(EW-SW){i_prev[SW-1]}}, i_prev} + {{(EW-SLOPE_W){1'b0}}, i_slope};
    assign cur_x = {{(EW-SW){i_cur[SW-1]}}, i_cur};
    assign o_min = (cand < cur_x) ? cand[SW-1:0] : i_cur;

endmodule

FILE: hdl/bp_truncated_linear_message.sv
// Min-sum belief propagation message with truncated linear pairwise cost.
// Depends on btlm_pkg and btlm_relax.
//
// One label is taken per transaction while the block is loading; i_valid and
// o_ready accept it and nothing is returned until the label count is reached.
// The label count is sampled as each label arrives. A message of n labels then
// runs a forward pass, a backward pass, a state that fixes the normalising base
// and an emit burst of n results. The cost buffer has a single read port, and
// both passes share the one relax unit. o_ready stays low from the last label
// until the final result has been handed to the output register. Costs are fixed
// point with four fraction bits; results saturate to 18 bits. Configuration goes
// through the APB port at byte addresses 0 (label_count), 4 (slope) and 8
// (trunc_cost).
module bp_truncated_linear_message
    import btlm_pkg::*;
#(
    parameter int MAX_LABELS = 64,
    parameter int COST_BITS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [COST_BITS-1:0] i_msg_a,
    input  logic signed [COST_BITS-1:0] i_msg_b,
    input  logic signed [COST_BITS-1:0] i_msg_c,
    input  logic signed [COST_BITS-1:0] i_unary_cost,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [OUT_W-1:0]     o_cost,
    output logic        [LABEL_W-1:0]   o_label_index,
    output logic                        o_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic        [CFG_AW-1:0]    paddr,
    input  logic        [CFG_DW-1:0]    pwdata,
    output logic        [CFG_DW-1:0]    prdata,
    output logic                        pready
);

    localparam int SW = COST_BITS + 2;
    localparam int EW = ((SW > TRUNC_W + 1) ? SW : TRUNC_W + 1) + 1;
    localparam int DW = (SW + 1 > OUT_W + 1) ? SW + 1 : OUT_W + 1;
    localparam int IW = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
    localparam int CW = $clog2(MAX_LABELS + 1);
    localparam int NW = (CW > LC_W) ? CW : LC_W;

    localparam logic signed [SW-1:0] MIN_RST = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [DW-1:0] OUT_HI  = {{(DW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [DW-1:0] OUT_LO  = ~OUT_HI;

    t_state                     r_state, n_state;
    logic        [LC_W-1:0]     r_label_count;
    logic        [SLOPE_W-1:0]  r_slope;
    logic        [TRUNC_W-1:0]  r_trunc;
    logic        [CW-1:0]       r_load_cnt;
    logic signed [SW-1:0]       r_min;
    logic        [CW-1:0]       r_n;
    logic signed [SW-1:0]       r_prev;
    logic signed [EW-1:0]       r_cap;
    logic signed [SW-1:0]       r_base;
    logic        [IW-1:0]       r_idx;
    logic        [CW-1:0]       r_left;
    logic                       r_pv;
    logic        [IW-1:0]       r_pidx;
    logic signed [SW-1:0]       r_rdata;
    logic signed [SW-1:0]       mem [MAX_LABELS];
    logic                       r_out_vld;
    logic signed [OUT_W-1:0]    r_cost;
    logic        [LABEL_W-1:0]  r_label;
    logic                       r_last;

    logic                       cfg_wr;
    logic                       in_acc;
    logic        [NW-1:0]       lc_x;
    logic        [CW-1:0]       n_eff;
    logic        [CW-1:0]       cnt_inc;
    logic                       last_load;
    logic signed [SW-1:0]       sum;
    logic signed [SW-1:0]       relax_out;
    logic signed [EW-1:0]       rdata_x;
    logic signed [EW-1:0]       prev_x;
    logic signed [SW-1:0]       clamped;
    logic signed [DW-1:0]       diff;
    logic signed [OUT_W-1:0]    sat;
    logic                       can_load;
    logic                       take;
    logic                       rd_en;
    logic                       wr_en;
    logic        [IW-1:0]       wr_addr;
    logic signed [SW-1:0]       wr_data;
    logic                       pass_done;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label_count <= LABEL_COUNT_RST;
            r_slope       <= SLOPE_RST;
            r_trunc       <= TRUNC_COST_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_LABEL_COUNT: r_label_count <= pwdata[LC_W-1:0];
                REG_SLOPE:       r_slope       <= pwdata[SLOPE_W-1:0];
                REG_TRUNC_COST:  r_trunc       <= pwdata[TRUNC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_LABEL_COUNT: prdata = {{(CFG_DW-LC_W){1'b0}}, r_label_count};
            REG_SLOPE:       prdata = {{(CFG_DW-SLOPE_W){1'b0}}, r_slope};
            REG_TRUNC_COST:  prdata = {{(CFG_DW-TRUNC_W){1'b0}}, r_trunc};
            default:         prdata = '0;
        endcase
    end

    // Load side
    assign o_ready = (r_state == ST_LOAD);
    assign in_acc  = i_valid & o_ready;

    assign lc_x = NW'(r_label_count);
    always_comb begin
        priority if (lc_x < NW'(2)) begin
            n_eff = CW'(2);
        end else if (lc_x > NW'(MAX_LABELS)) begin
            n_eff = CW'(MAX_LABELS);
        end else begin
            n_eff = CW'(lc_x);
        end
    end

    assign cnt_inc   = r_load_cnt + 1'b1;
    assign last_load = (cnt_inc >= n_eff);

    assign sum = {{2{i_msg_a[COST_BITS-1]}}, i_msg_a}
               + {{2{i_msg_b[COST_BITS-1]}}, i_msg_b}
               + {{2{i_msg_c[COST_BITS-1]}}, i_msg_c}
               + {{2{i_unary_cost[COST_BITS-1]}}, i_unary_cost};

    // Shared relax unit
    btlm_relax #(
        .SW (SW),
        .EW (EW)
    ) u_relax (
        .i_prev  (r_prev),
        .i_slope (r_slope),
        .i_cur   (r_rdata),
        .o_min   (relax_out)
    );

    // Emit arithmetic: clamp to the cap, subtract the base, saturate
    assign rdata_x = {{(EW-SW){r_rdata[SW-1]}}, r_rdata};
    assign prev_x  = {{(EW-SW){r_prev[SW-1]}}, r_prev};
    assign clamped = (rdata_x > r_cap) ? r_cap[SW-1:0] : r_rdata;
    assign diff    = {{(DW-SW){clamped[SW-1]}}, clamped} - {{(DW-SW){r_base[SW-1]}}, r_base};

    always_comb begin
        priority if (diff > OUT_HI) begin
            sat = OUT_HI[OUT_W-1:0];
        end else if (diff < OUT_LO) begin
            sat = OUT_LO[OUT_W-1:0];
        end else begin
            sat = diff[OUT_W-1:0];
        end
    end

    assign can_load  = ~r_out_vld | i_ready;
    assign take      = (r_state == ST_EMIT) & r_pv & can_load;
    assign pass_done = r_pv & (r_left == '0);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        wr_addr = r_pidx;
        wr_data = relax_out;
        unique case (r_state)
            ST_LOAD: begin
                wr_addr = r_load_cnt[IW-1:0];
                wr_data = sum;
                if (in_acc) begin
                    wr_en = 1'b1;
                    if (last_load) begin
                        n_state = ST_FWD;
                    end
                end
            end
            ST_FWD, ST_BWD: begin
                rd_en = (r_left != '0);
                wr_en = r_pv;
                if (pass_done) begin
                    n_state = (r_state == ST_FWD) ? ST_BWD : ST_BASE;
                end
            end
            ST_BASE: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                rd_en = (r_left != '0) & (~r_pv | take);
                if (take && r_left == '0) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // Cost buffer
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[r_idx];
        end
    end

    // Control registers of the passes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
            r_min      <= MIN_RST;
            r_pv       <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_load_cnt <= last_load ? '0 : cnt_inc;
                if (sum < r_min) begin
                    r_min <= sum;
                end
            end
            if (r_state == ST_FWD && pass_done) begin
                r_min <= MIN_RST;
            end

            if (rd_en) begin
                r_pv <= 1'b1;
            end else if (r_state == ST_EMIT) begin
                r_pv <= r_pv & ~take;
            end else begin
                r_pv <= 1'b0;
            end

            if (take) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc && r_load_cnt == '0) begin
            r_prev <= sum;
        end
        if ((r_state == ST_FWD || r_state == ST_BWD) && r_pv) begin
            r_prev <= relax_out;
        end
        if (r_state == ST_FWD) begin
            r_cap <= {{(EW-SW){r_min[SW-1]}}, r_min} + {{(EW-TRUNC_W){1'b0}}, r_trunc};
        end
        if (r_state == ST_BASE) begin
            r_base <= (prev_x > r_cap) ? r_cap[SW-1:0] : r_prev;
        end

        if (rd_en) begin
            r_pidx <= r_idx;
            r_left <= r_left - 1'b1;
            r_idx  <= (r_state == ST_BWD) ? r_idx - 1'b1 : r_idx + 1'b1;
        end
        if (in_acc && last_load) begin
            r_n    <= n_eff;
            r_idx  <= IW'(1);
            r_left <= n_eff - 1'b1;
        end
        if (r_state == ST_FWD && pass_done) begin
            r_idx  <= IW'(r_n - CW'(2));
            r_left <= r_n - 1'b1;
        end
        if (r_state == ST_BASE) begin
            r_idx  <= '0;
            r_left <= r_n;
        end

        if (take) begin
            r_cost  <= sat;
            r_label <= LABEL_W'(r_pidx);
            r_last  <= (r_left == '0);
        end
    end

    assign o_valid       = r_out_vld;
    assign o_cost        = r_cost;
    assign o_label_index = r_label;
    assign o_last        = r_last;

endmodule

FILE: hdl/btlm_checker.sv
// Port-level checks for bp_truncated_linear_message, attached by bind.
// Depends on btlm_pkg for field widths.
module btlm_checker
    import btlm_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_ready,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic signed [OUT_W-1:0]   o_cost,
    input logic        [LABEL_W-1:0] o_label_index,
    input logic                      o_last
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_cost)
                               && $stable(o_label_index) && $stable(o_last))
        else $error("stalled result transaction changed");

    a_burst_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last
            |=> o_valid && (o_label_index == $past(o_label_index) + 6'd1))
        else $error("result burst broke label order");

    a_no_load_mid_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> !o_ready)
        else $error("input taken during a result burst");

endmodule

bind bp_truncated_linear_message btlm_checker u_btlm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_cost        (o_cost),
    .o_label_index (o_label_index),
    .o_last        (o_last)
);
